// ----- hdl/assert_macros.svh -----
// assertion macros shared by the deque rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is low
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that something never happens
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hdl/bdq_pkg.sv -----
// package: sizes, codes and shared types of the bounded deque
package bdq_pkg;

    localparam int DEPTH     = 1024;
    localparam int WORD_BITS = 16;
    localparam int CAP_BITS  = 11;
    localparam int KIND_BITS = 3;
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int CMP_BITS  = (CAP_BITS > CNT_BITS) ? CAP_BITS : CNT_BITS;

    typedef enum logic [KIND_BITS-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_BACK  = 3'd1,
        K_POP_FRONT  = 3'd2,
        K_POP_BACK   = 3'd3,
        K_QUERY      = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic accept;
        logic apply;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic                 op_ok;
        logic                 ends_valid;
        logic [WORD_BITS-1:0] front_word;
        logic [WORD_BITS-1:0] rear_word;
        logic                 is_empty;
        logic                 is_full;
    } t_result;

    // ring slot arithmetic, offset below DEPTH
    function automatic logic [ADDR_BITS-1:0] slot_add(input logic [ADDR_BITS-1:0] base,
                                                      input logic [CNT_BITS-1:0]  offset);
        logic [CNT_BITS:0] sum;
        sum = (CNT_BITS+1)'(base) + (CNT_BITS+1)'(offset);
        if (sum >= (CNT_BITS+1)'(DEPTH)) begin
            sum = sum - (CNT_BITS+1)'(DEPTH);
        end
        return sum[ADDR_BITS-1:0];
    endfunction

endpackage

// ----- hdl/bdq_in_if.sv -----
// interface: operation channel into the deque
interface bdq_in_if;
    logic                          valid;
    logic                          ready;
    logic [bdq_pkg::KIND_BITS-1:0] kind;
    logic [bdq_pkg::WORD_BITS-1:0] data_value;

    modport source (output valid, kind, data_value, input ready);
    modport sink   (input valid, kind, data_value, output ready);
endinterface

// ----- hdl/bdq_out_if.sv -----
// interface: result channel out of the deque
interface bdq_out_if;
    logic                          valid;
    logic                          ready;
    logic                          op_ok;
    logic                          ends_valid;
    logic [bdq_pkg::WORD_BITS-1:0] front_word;
    logic [bdq_pkg::WORD_BITS-1:0] rear_word;
    logic                          is_empty;
    logic                          is_full;

    modport source (output valid, op_ok, ends_valid, front_word, rear_word, is_empty,
                    is_full, input ready);
    modport sink   (input valid, op_ok, ends_valid, front_word, rear_word, is_empty,
                    is_full, output ready);
endinterface

// ----- hdl/bdq_ram.sv -----
// generic single-write, single-read ram with registered read data
module bdq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/bdq_ctrl.sv -----
// controller: operation sequencing and result handshake
`include "assert_macros.svh"

module bdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output bdq_pkg::t_cmd o_cmd
);
    bdq_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        out_free   = !r_out_valid || i_out_ready;
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            bdq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = bdq_pkg::S_UPD;
                end
            end
            bdq_pkg::S_UPD: begin
                o_cmd.apply = 1'b1;
                if (out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = bdq_pkg::S_IDLE;
                end else begin
                    n_state = bdq_pkg::S_HOLD;
                end
            end
            bdq_pkg::S_HOLD: begin
                if (out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = bdq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bdq_pkg::S_IDLE;
            end
        endcase
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_CLK(a_accept_then_upd, i_clk, i_rst_n, o_cmd.accept |=> r_state == bdq_pkg::S_UPD, "accept not followed by update")
    `ASSERT_CLK(a_load_sets_valid, i_clk, i_rst_n, o_cmd.load |=> r_out_valid, "load did not raise result valid")
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, o_cmd.load && r_out_valid && !i_out_ready, "pending result overwritten")
endmodule

// ----- hdl/bdq_dpath.sv -----
// datapath: ring pointers, capacity, end registers, ring memory, result register
`include "assert_macros.svh"

module bdq_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bdq_pkg::t_cmd                       i_cmd,
    input  logic [bdq_pkg::KIND_BITS-1:0]       i_kind,
    input  logic [bdq_pkg::WORD_BITS-1:0]       i_data_value,
    input  logic                                i_cfg_we,
    input  logic [bdq_pkg::CAP_BITS-1:0]        i_cfg_wdata,
    output bdq_pkg::t_result                    o_result
);
    localparam int AB = bdq_pkg::ADDR_BITS;
    localparam int CB = bdq_pkg::CNT_BITS;
    localparam int WB = bdq_pkg::WORD_BITS;

    logic [bdq_pkg::CAP_BITS-1:0] r_cap;
    logic [AB-1:0]                r_head, n_head;
    logic [CB-1:0]                r_count, n_count;
    logic [WB-1:0]                r_front, n_front;
    logic [WB-1:0]                r_rear, n_rear;
    logic                         r_ok, n_ok;
    logic                         r_ram_front, n_ram_front;
    logic                         r_ram_rear, n_ram_rear;
    bdq_pkg::t_result             r_res;

    logic [CB-1:0] cap_eff;
    logic          full, empty;
    logic          set_front, set_rear;
    logic          we, re;
    logic [AB-1:0] waddr, raddr;
    logic [WB-1:0] rd_data;

    always_comb begin
        if (bdq_pkg::CMP_BITS'(r_cap) > bdq_pkg::CMP_BITS'(bdq_pkg::DEPTH)) begin
            cap_eff = CB'(bdq_pkg::DEPTH);
        end else begin
            cap_eff = CB'(r_cap);
        end
        full  = r_count >= cap_eff;
        empty = r_count == '0;
    end

    // decode of one operation against the current ring state
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_ok        = 1'b1;
        n_ram_front = 1'b0;
        n_ram_rear  = 1'b0;
        set_front   = 1'b0;
        set_rear    = 1'b0;
        we          = 1'b0;
        re          = 1'b0;
        waddr       = r_head;
        raddr       = r_head;
        case (i_kind)
            bdq_pkg::K_PUSH_FRONT: begin
                if (full) begin
                    n_ok = 1'b0;
                end else begin
                    n_head    = bdq_pkg::slot_add(r_head, CB'(bdq_pkg::DEPTH - 1));
                    n_count   = r_count + CB'(1);
                    we        = 1'b1;
                    waddr     = n_head;
                    set_front = 1'b1;
                    set_rear  = empty;
                end
            end
            bdq_pkg::K_PUSH_BACK: begin
                if (full) begin
                    n_ok = 1'b0;
                end else begin
                    n_count   = r_count + CB'(1);
                    we        = 1'b1;
                    waddr     = bdq_pkg::slot_add(r_head, r_count);
                    set_rear  = 1'b1;
                    set_front = empty;
                end
            end
            bdq_pkg::K_POP_FRONT: begin
                if (empty) begin
                    n_ok = 1'b0;
                end else begin
                    n_head      = bdq_pkg::slot_add(r_head, CB'(1));
                    n_count     = r_count - CB'(1);
                    re          = 1'b1;
                    raddr       = n_head;
                    n_ram_front = 1'b1;
                end
            end
            bdq_pkg::K_POP_BACK: begin
                if (empty) begin
                    n_ok = 1'b0;
                end else begin
                    n_count    = r_count - CB'(1);
                    re         = 1'b1;
                    // new rear sits at head + count - 2; with one entry left the offset is clamped to zero
                    raddr      = bdq_pkg::slot_add(r_head, (r_count > CB'(1)) ?
                                                   r_count - CB'(2) : '0);
                    n_ram_rear = 1'b1;
                end
            end
            default: begin
                n_ok = 1'b1;
            end
        endcase
    end

    always_comb begin
        if (i_cmd.accept && set_front) begin
            n_front = i_data_value;
        end else if (i_cmd.apply && r_ram_front) begin
            n_front = rd_data;
        end else begin
            n_front = r_front;
        end
        if (i_cmd.accept && set_rear) begin
            n_rear = i_data_value;
        end else if (i_cmd.apply && r_ram_rear) begin
            n_rear = rd_data;
        end else begin
            n_rear = r_rear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= bdq_pkg::CAP_BITS'(bdq_pkg::DEPTH);
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
        r_rear  <= n_rear;
        if (i_cmd.accept) begin
            r_ok        <= n_ok;
            r_ram_front <= n_ram_front;
            r_ram_rear  <= n_ram_rear;
        end
        if (i_cmd.load) begin
            r_res.op_ok      <= r_ok;
            r_res.ends_valid <= !empty;
            r_res.front_word <= empty ? '0 : n_front;
            r_res.rear_word  <= empty ? '0 : n_rear;
            r_res.is_empty   <= empty;
            r_res.is_full    <= full;
        end
    end

    bdq_ram #(
        .WIDTH (WB),
        .DEPTH (bdq_pkg::DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && we),
        .i_waddr (waddr),
        .i_wdata (i_data_value),
        .i_re    (i_cmd.accept && re),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    assign o_result = r_res;

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CB'(bdq_pkg::DEPTH), "entry count above ring depth")
    `ASSERT_CLK(a_push_front_word, i_clk, i_rst_n, (i_cmd.accept && set_front) |=> r_front == $past(i_data_value), "front word not taken from push")
    `ASSERT_NEVER(a_no_write_full, i_clk, i_rst_n, we && full, "ring written while full")
endmodule

// ----- hdl/bounded_double_ended_queue_core.sv -----
// top level: bounded deque on a ring buffer with handshake channels
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    kind[2:0], data_value[15:0]
//  o_out     out  valid/ready    op_ok, ends_valid, front_word, rear_word, is_empty, is_full
//  i_cfg_*   in   write enable   capacity_in_use[10:0]
//
//  each operation: accept beat, then the update state takes the ring ram read of the new end
//  the ram's read data is registered, hence the update state; pushes write on the accept beat
//  a new op is taken while an earlier result still waits in the output register
//  a stalled output holds the block after the result is computed, no beat is lost
//  synchronous active-low reset clears pointers and count, capacity back to full depth
//  no ram clear
module bounded_double_ended_queue_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bdq_in_if.sink                       i_in,
    bdq_out_if.source                    o_out,
    input  logic                         i_cfg_we,
    input  logic [bdq_pkg::CAP_BITS-1:0] i_cfg_wdata
);
    bdq_pkg::t_cmd    cmd;
    bdq_pkg::t_result result;

    // sequencing: idle, ram result update, wait for output space
    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // ring pointers, end words and the result register
    bdq_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_kind       (i_in.kind),
        .i_data_value (i_in.data_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_result     (result)
    );

    // result beat fields
    assign o_out.op_ok      = result.op_ok;
    assign o_out.ends_valid = result.ends_valid;
    assign o_out.front_word = result.front_word;
    assign o_out.rear_word  = result.rear_word;
    assign o_out.is_empty   = result.is_empty;
    assign o_out.is_full    = result.is_full;
endmodule

// ----- tb/sv/bdq_mirror_check.sv -----
// checker: mirrors the deque state, predicts each result beat and compares it
module bdq_mirror_check
    import bdq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    bdq_in_if                   i_op_mon,
    bdq_out_if                  i_res_mon,
    input  logic                i_cfg_we,
    input  logic [CAP_BITS-1:0] i_cfg_wdata,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [WORD_BITS-1:0] ring_words [DEPTH];
    int                   front_slot;
    int                   held;
    logic [CAP_BITS-1:0]  cap_reg;
    t_result              due_ends [$];
    int                   mismatches = 0;
    int                   waiting    = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    // applies one operation to the mirror, returns the ends as they stand afterwards
    function automatic t_result mirror_apply(input logic [KIND_BITS-1:0] kind,
                                             input logic [WORD_BITS-1:0] word);
        int      room;
        bit      full;
        bit      ok;
        t_result r;
        room = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
        full = held >= room;
        ok   = 1'b1;
        case (kind)
            K_PUSH_FRONT: begin
                if (full) begin
                    ok = 1'b0;
                end else begin
                    front_slot = (front_slot + DEPTH - 1) % DEPTH;
                    ring_words[front_slot] = word;
                    held++;
                end
            end
            K_PUSH_BACK: begin
                if (full) begin
                    ok = 1'b0;
                end else begin
                    ring_words[(front_slot + held) % DEPTH] = word;
                    held++;
                end
            end
            K_POP_FRONT: begin
                if (held == 0) begin
                    ok = 1'b0;
                end else begin
                    front_slot = (front_slot + 1) % DEPTH;
                    held--;
                end
            end
            K_POP_BACK: begin
                if (held == 0) begin
                    ok = 1'b0;
                end else begin
                    held--;
                end
            end
            default: begin
            end
        endcase
        r.op_ok      = ok;
        r.ends_valid = held != 0;
        r.front_word = (held != 0) ? ring_words[front_slot] : '0;
        r.rear_word  = (held != 0) ? ring_words[(front_slot + held - 1) % DEPTH] : '0;
        r.is_empty   = held == 0;
        r.is_full    = held >= room;
        return r;
    endfunction

    function automatic void match_field(input string field, input logic [WORD_BITS-1:0] want,
                                        input logic [WORD_BITS-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            front_slot = 0;
            held       = 0;
            cap_reg    = CAP_BITS'(DEPTH);
            due_ends.delete();
        end else begin
            if (i_cfg_we) begin
                cap_reg = i_cfg_wdata;
            end
            // result side first, the beat taken now is never the result of this edge's op
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (due_ends.size() == 0) begin
                    $error("result beat with nothing outstanding");
                    mismatches++;
                end else begin
                    want = due_ends.pop_front();
                    match_field("op_ok", want.op_ok, i_res_mon.op_ok);
                    match_field("ends_valid", want.ends_valid, i_res_mon.ends_valid);
                    match_field("front_word", want.front_word, i_res_mon.front_word);
                    match_field("rear_word", want.rear_word, i_res_mon.rear_word);
                    match_field("is_empty", want.is_empty, i_res_mon.is_empty);
                    match_field("is_full", want.is_full, i_res_mon.is_full);
                end
            end
            if (i_op_mon.valid && i_op_mon.ready) begin
                due_ends.insert(due_ends.size(),
                                mirror_apply(i_op_mon.kind, i_op_mon.data_value));
            end
        end
        waiting = due_ends.size();
    end

endmodule

// ----- tb/sv/tb_bounded_double_ended_queue_core.sv -----
// testbench top: drives the deque with directed and random operations and gives the verdict
module tb_bounded_double_ended_queue_core;
    timeunit 1ns;
    timeprecision 1ps;
    import bdq_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 4;
    localparam int IDLE_LIMIT     = 2000;  // cycles without any beat before giving up
    localparam int RX_HOLD_CYCLES = 300;   // long receiver stall, fills the block
    localparam int SETTLE_CYCLES  = 2;     // padding after the last result, before a cfg write
    localparam int DRAIN_CYCLES   = 8;
    localparam int KIND_TOP       = (1 << KIND_BITS) - 1;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CAP_BITS-1:0] cfg_wdata = '0;

    bit calm        = 1'b0;  // no idling on either side while set
    bit rx_hold_req = 1'b0;  // asks the receiver for one long stall

    int fail_count;
    int pending;
    int idle_cycles = 0;

    bdq_in_if  op_ch ();
    bdq_out_if res_ch ();

    bounded_double_ended_queue_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (op_ch),
        .o_out       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    bdq_mirror_check ends_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_op_mon     (op_ch),
        .i_res_mon    (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (calm) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 88) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // data word with a bias toward all zeros and all ones
    function automatic logic [WORD_BITS-1:0] pick_word();
        case ($urandom_range(0, 15))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return WORD_BITS'($urandom);
            end
        endcase
    endfunction

    // one op beat: optional idle with junk payload, then hold valid until taken
    task automatic send_op(input logic [KIND_BITS-1:0] kind, input logic [WORD_BITS-1:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            op_ch.valid      = 1'b0;
            op_ch.kind       = KIND_BITS'($urandom);
            op_ch.data_value = WORD_BITS'($urandom);
            repeat (gap) @(negedge clk);
        end
        op_ch.valid      = 1'b1;
        op_ch.kind       = kind;
        op_ch.data_value = word;
        do begin
            @(posedge clk);
        end while (!op_ch.ready);
        @(negedge clk);
    endtask

    // sender stops and waits for every outstanding result, block is then idle
    task automatic settle();
        op_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
        settle();
        cfg_we    = 1'b1;
        cfg_wdata = cap;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_wdata = CAP_BITS'($urandom);
    endtask

    // random mix: push_pct pushes, pop_pct pops, the rest queries and unused codes
    task automatic run_random_ops(input int count, input int push_pct, input int pop_pct);
        int                   roll;
        logic [KIND_BITS-1:0] kind;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct) begin
                kind = $urandom_range(0, 1) ? K_PUSH_BACK : K_PUSH_FRONT;
            end else if (roll < push_pct + pop_pct) begin
                kind = $urandom_range(0, 1) ? K_POP_BACK : K_POP_FRONT;
            end else if ($urandom_range(0, 1)) begin
                kind = K_QUERY;
            end else begin
                kind = KIND_BITS'($urandom_range(KIND_TOP, int'(K_QUERY) + 1));
            end
            send_op(kind, pick_word());
        end
    endtask

    // receiver: random ready with gaps, plus the one long stall on request
    initial begin : rx_side
        int rx_gap;
        rx_gap       = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_req) begin
                res_ch.ready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
            end else if (rx_gap > 0) begin
                res_ch.ready = 1'b0;
                rx_gap--;
            end else begin
                res_ch.ready = 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    rx_gap = pick_gap();
                end
            end
        end
    end

    // watchdog: any beat on any port restarts the count
    always @(posedge clk) begin
        if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        op_ch.valid      = 1'b0;
        op_ch.kind       = K_QUERY;
        op_ch.data_value = '0;
        rst_n            = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // directed: pops on an empty deque fail, ends read back as zero
        send_op(K_POP_FRONT, 16'hFFFF);
        send_op(K_POP_BACK, 16'h1234);
        send_op(K_QUERY, '0);
        // unused kind codes behave as a query
        for (int c = int'(K_QUERY) + 1; c <= KIND_TOP; c++) begin
            send_op(KIND_BITS'(c), pick_word());
        end
        // push front from slot 0 wraps the head to the top of the ring
        send_op(K_PUSH_FRONT, 16'hFFFF);
        send_op(K_PUSH_BACK, 16'h0000);
        send_op(K_PUSH_FRONT, 16'h8001);
        send_op(K_PUSH_BACK, 16'h7FFE);
        send_op(K_QUERY, 16'hFFFF);
        send_op(K_POP_FRONT, '0);
        send_op(K_POP_BACK, '0);
        send_op(K_POP_BACK, '0);
        send_op(K_POP_FRONT, '0);
        send_op(K_POP_BACK, '0);

        // capacity one: second push fails, deque reports full
        write_capacity(CAP_BITS'(1));
        send_op(K_PUSH_BACK, 16'hA5A5);
        send_op(K_PUSH_FRONT, 16'h5A5A);

        // capacity zero with one entry held: pushes fail, pops still work,
        // and the empty deque reports both empty and full
        write_capacity('0);
        send_op(K_PUSH_FRONT, 16'h0F0F);
        send_op(K_QUERY, '0);
        send_op(K_POP_BACK, '0);
        send_op(K_POP_FRONT, '0);
        write_capacity(CAP_BITS'(DEPTH));

        // random phases across small, zero, saturating and boundary capacities
        write_capacity(CAP_BITS'(5));
        run_random_ops(80, 45, 40);
        write_capacity(CAP_BITS'(1));
        run_random_ops(60, 45, 40);

        // a stretch without idling, push heavy so the count climbs
        write_capacity(CAP_BITS'(12));
        calm = 1'b1;
        run_random_ops(70, 70, 20);
        calm = 1'b0;

        // capacity dropped below the count: nothing lost, pops drain it
        write_capacity(CAP_BITS'(3));
        run_random_ops(60, 30, 55);

        // long receiver stall while ops keep coming, input backs up
        write_capacity(CAP_BITS'(6));
        rx_hold_req = 1'b1;
        run_random_ops(60, 60, 30);

        write_capacity('0);
        run_random_ops(50, 40, 40);
        write_capacity('1);  // above the ring depth, saturates
        run_random_ops(50, 50, 40);
        write_capacity(CAP_BITS'(DEPTH + 1));
        run_random_ops(50, 50, 40);
        write_capacity(CAP_BITS'(2));
        run_random_ops(60, 50, 40);
        write_capacity(CAP_BITS'(9));
        run_random_ops(80, 50, 45);

        // fill the whole ring, then drain part of it under a saturated capacity
        write_capacity(CAP_BITS'(DEPTH));
        run_random_ops(1100, 97, 1);
        write_capacity('1);
        run_random_ops(150, 30, 65);

        // all ops taken: wait for the last results, then a short quiet tail
        op_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
